// ----- design/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_datapath and sorted_priority_queue; no dependencies.
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int PRIO_W           = 16;
    localparam int DATA_W           = 32;
    localparam int OCC_W            = 5;

    // Input action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic {
        CS_IDLE,
        CS_HOLD
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    insert;
        logic    remove;
        status_t code;
    } spq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
    } spq_stat_t;

endpackage

// ----- design/spq_ctrl.sv -----
// Controller for the sorted priority queue: handshakes and command decode.
// Depends on spq_pkg.
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    output logic              out_valid,
    input  logic              out_stall,
    input  spq_pkg::spq_stat_t dp_stat,
    output spq_pkg::spq_cmd_t  dp_cmd
);
    import spq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, handshake and commands
    always_comb
    begin
        in_stall   = (state_reg == CS_HOLD) && out_stall;
        out_valid  = (state_reg == CS_HOLD);
        accept     = in_valid && !in_stall;
        state_next = state_reg;
        dp_cmd     = '{load: 1'b0, insert: 1'b0, remove: 1'b0, code: STAT_OK};

        unique case (state_reg)
            CS_IDLE:
            begin
                if (accept)
                begin
                    state_next = CS_HOLD;
                end
            end
            CS_HOLD:
            begin
                if (accept)
                begin
                    state_next = CS_HOLD;
                end
                else if (!out_stall)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase

        // Decode the accepted transfer into a datapath command
        if (accept)
        begin
            dp_cmd.load = 1'b1;
            if (action == ACT_INSERT)
            begin
                if (dp_stat.full)
                begin
                    dp_cmd.code = STAT_OVERFLOW;
                end
                else
                begin
                    dp_cmd.insert = 1'b1;
                end
            end
            else
            begin
                if (dp_stat.empty)
                begin
                    dp_cmd.code = STAT_UNDERFLOW;
                end
                else
                begin
                    dp_cmd.remove = 1'b1;
                end
            end
        end
    end

endmodule

// ----- design/spq_datapath.sv -----
// Datapath for the sorted priority queue: slot shift line, entry count and
// result registers. Depends on spq_pkg.
module spq_datapath #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spq_pkg::spq_cmd_t                dp_cmd,
    output spq_pkg::spq_stat_t               dp_stat,
    input  logic        [spq_pkg::PRIO_W-1:0] priority_req,
    input  logic signed [spq_pkg::DATA_W-1:0] item_data,
    output logic signed [spq_pkg::DATA_W-1:0] head_data,
    output logic        [spq_pkg::PRIO_W-1:0] head_priority,
    output logic                             is_empty,
    output logic        [1:0]                status,
    output logic        [spq_pkg::OCC_W-1:0]  occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic        [PRIO_W-1:0] slot_pri_reg  [CAPACITY];
    logic        [PRIO_W-1:0] slot_pri_next [CAPACITY];
    logic signed [DATA_W-1:0] slot_data_reg  [CAPACITY];
    logic signed [DATA_W-1:0] slot_data_next [CAPACITY];
    logic        [CNT_W-1:0]  count_reg;
    logic        [CNT_W-1:0]  count_next;
    logic        [CAPACITY-1:0] ge_vec;
    logic        [CAPACITY-1:0] ge_prev;
    logic        [CNT_W+OCC_W-1:0] occ_wide;

    logic signed [DATA_W-1:0] head_data_reg;
    logic        [PRIO_W-1:0] head_pri_reg;
    logic                     empty_reg;
    status_t                  status_reg;
    logic        [OCC_W-1:0]  occ_reg;

    assign dp_stat.full  = (count_reg >= CNT_W'(CAPACITY));
    assign dp_stat.empty = (count_reg == '0);

    // Compare the new priority against every held slot in parallel
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            ge_vec[k] = (count_reg > CNT_W'(k)) && (slot_pri_reg[k] >= priority_req);
        end
    end

    assign ge_prev = {ge_vec[CAPACITY-2:0], 1'b1};

    // Next slot contents: hold, insert-shift down, or remove-shift up
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            slot_pri_next[k]  = slot_pri_reg[k];
            slot_data_next[k] = slot_data_reg[k];
        end
        count_next = count_reg;

        if (dp_cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
            for (int k = 0; k < CAPACITY; k++)
            begin
                if (!ge_vec[k] && ge_prev[k])
                begin
                    slot_pri_next[k]  = priority_req;
                    slot_data_next[k] = item_data;
                end
            end
            for (int k = 1; k < CAPACITY; k++)
            begin
                if (!ge_vec[k] && !ge_prev[k])
                begin
                    slot_pri_next[k]  = slot_pri_reg[k-1];
                    slot_data_next[k] = slot_data_reg[k-1];
                end
            end
        end
        else if (dp_cmd.remove)
        begin
            count_next = count_reg - CNT_W'(1);
            for (int k = 0; k < CAPACITY - 1; k++)
            begin
                slot_pri_next[k]  = slot_pri_reg[k+1];
                slot_data_next[k] = slot_data_reg[k+1];
            end
        end
    end

    assign occ_wide = {{OCC_W{1'b0}}, count_next};

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Slot shift line and result registers
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            slot_pri_reg[k]  <= slot_pri_next[k];
            slot_data_reg[k] <= slot_data_next[k];
        end
        if (dp_cmd.load)
        begin
            empty_reg  <= (count_next == '0);
            status_reg <= dp_cmd.code;
            occ_reg    <= occ_wide[OCC_W-1:0];
            if (count_next == '0)
            begin
                head_data_reg <= '0;
                head_pri_reg  <= '0;
            end
            else
            begin
                head_data_reg <= slot_data_next[0];
                head_pri_reg  <= slot_pri_next[0];
            end
        end
    end

    assign head_data     = head_data_reg;
    assign head_priority = head_pri_reg;
    assign is_empty      = empty_reg;
    assign status        = status_reg;
    assign occupancy     = occ_reg;

endmodule

// ----- design/sorted_priority_queue.sv -----
// Sorted priority queue: each transfer inserts an entry or removes the head,
// and one result transfer describes the queue afterwards. One transfer per
// cycle is accepted while in_stall is low; the whole operation completes in the
// cycle of acceptance through a parallel compare of the new priority against all
// CAPACITY slots and a one-slot shift, and the result appears in the output
// register on the next cycle. A new transfer is taken while a result waits
// unless out_stall is high. Equal priorities leave in arrival order. Depends on
// spq_pkg, spq_ctrl and spq_datapath.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic        [spq_pkg::PRIO_W-1:0] priority_req,
    input  logic signed [spq_pkg::DATA_W-1:0] item_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [spq_pkg::DATA_W-1:0] head_data,
    output logic        [spq_pkg::PRIO_W-1:0] head_priority,
    output logic                             is_empty,
    output logic        [1:0]                status,
    output logic        [spq_pkg::OCC_W-1:0]  occupancy
);
    import spq_pkg::*;

    spq_cmd_t  dp_cmd;
    spq_stat_t dp_stat;

    // Handshake control and command decode
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    // Slot storage and result registers
    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .dp_stat       (dp_stat),
        .priority_req  (priority_req),
        .item_data     (item_data),
        .head_data     (head_data),
        .head_priority (head_priority),
        .is_empty      (is_empty),
        .status        (status),
        .occupancy     (occupancy)
    );

endmodule
